// File: hw/rtl/hla_pkg.sv
`default_nettype none

package hla_pkg;

  // Divider geometry: a 16-bit numerator over a 9-bit divisor, two quotient bits a stage.
  localparam int unsigned NUM_W      = 16;
  localparam int unsigned DEN_W      = 9;
  localparam int unsigned QUO_W      = 8;
  localparam int unsigned DIV_BITS   = 2;
  localparam int unsigned DIV_STAGES = QUO_W / DIV_BITS;

  // Register stages inside one channel rebuild unit.
  localparam int unsigned CHAN_STAGES = 3;

  // Scale constants of the 0..255 hue and luminance range.
  localparam logic [7:0] LUM_HALF       = 8'd127;
  localparam logic [7:0] HUE_SIXTH      = 8'd42;
  localparam logic [7:0] HUE_TWELFTH    = 8'd21;
  localparam logic [7:0] HUE_THIRD      = 8'd85;
  localparam logic [7:0] HUE_HALF       = 8'd127;
  localparam logic [7:0] HUE_TWO_THIRDS = 8'd170;
  localparam logic [7:0] FULL_SCALE     = 8'd255;

  // Darken factor 333/1000 as a reciprocal: floor(l * 333 / 1000) for any 8-bit l.
  localparam logic [18:0] DARK_MUL   = 19'd349176;
  localparam int unsigned DARK_SHIFT = 20;

  // Reciprocal of 42, exact for numerators below 2**14.
  localparam logic [14:0] DIV42_MUL   = 15'd24967;
  localparam int unsigned DIV42_SHIFT = 20;

  // Channel that holds the maximum of the input pixel.
  typedef enum logic [1:0] {
    MAX_RED   = 2'd0,
    MAX_GREEN = 2'd1,
    MAX_BLUE  = 2'd2
  } hla_maxc_e;

  // Part of the hue circle that a channel falls in.
  typedef enum logic [1:0] {
    SEC_RAMP = 2'd0,
    SEC_HIGH = 2'd1,
    SEC_LOW  = 2'd2
  } hla_sec_e;

  // Color of one pixel in HSL together with its adjusted luminance.
  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] lum;
    logic [7:0] nlum;
    logic       grey;
  } hla_hsl_t;

  // Floor of x / 255 for x below 2**16: x / 256 plus up to two corrections.
  function automatic logic [8:0] div255(input logic [15:0] x);
    logic [7:0] q0;
    logic [8:0] r;
    logic [8:0] q;
    q0 = x[15:8];
    r  = {1'b0, x[7:0]} + {1'b0, q0};
    q  = {1'b0, q0} + {8'd0, (r >= 9'd255)} + {8'd0, (r >= 9'd510)};
    return q;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hla_div.sv
`default_nettype none

// Pipelined restoring divider: a fixed number of quotient bits resolved in each stage.
module hla_div (
  input  wire logic                          clk_i,
  input  wire logic [hla_pkg::NUM_W-1:0]     num_i,
  input  wire logic [hla_pkg::DEN_W-1:0]     den_i,
  output logic      [hla_pkg::QUO_W-1:0]     quo_o
);

  localparam int unsigned CMP_W = hla_pkg::NUM_W + 1;

  logic [hla_pkg::NUM_W-1:0] rem_q [hla_pkg::DIV_STAGES];
  logic [hla_pkg::DEN_W-1:0] den_q [hla_pkg::DIV_STAGES];
  logic [hla_pkg::QUO_W-1:0] quo_q [hla_pkg::DIV_STAGES];

  for (genvar k = 0; k < int'(hla_pkg::DIV_STAGES); k++) begin : g_stage
    logic [hla_pkg::NUM_W-1:0] rem_in;
    logic [hla_pkg::DEN_W-1:0] den_in;
    logic [hla_pkg::QUO_W-1:0] quo_in;
    logic [hla_pkg::NUM_W-1:0] rem_d;
    logic [hla_pkg::QUO_W-1:0] quo_d;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    // Trial subtraction of the shifted divisor for each quotient bit of this stage.
    always_comb begin
      logic [CMP_W-1:0] trial;
      rem_d = rem_in;
      quo_d = quo_in;
      for (int j = 0; j < int'(hla_pkg::DIV_BITS); j++) begin
        trial = CMP_W'(den_in) << (int'(hla_pkg::QUO_W) - 1 - k * int'(hla_pkg::DIV_BITS) - j);
        if ({1'b0, rem_d} >= trial) begin
          rem_d = rem_d - trial[hla_pkg::NUM_W-1:0];
          quo_d[int'(hla_pkg::QUO_W) - 1 - k * int'(hla_pkg::DIV_BITS) - j] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_d;
      den_q[k] <= den_in;
      quo_q[k] <= quo_d;
    end
  end

  assign quo_o = quo_q[hla_pkg::DIV_STAGES-1];

endmodule

`default_nettype wire

// File: hw/rtl/hla_front.sv
`default_nettype none

// RGB to HSL conversion and luminance adjustment.
module hla_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire logic              mode_i,
  input  wire logic [7:0]        red_i,
  input  wire logic [7:0]        green_i,
  input  wire logic [7:0]        blue_i,
  output logic                   valid_o,
  output hla_pkg::hla_hsl_t      hsl_o
);

  typedef struct packed {
    logic [7:0]         lum;
    logic               grey;
    logic               mode;
    hla_pkg::hla_maxc_e maxc;
  } side_t;

  // Stage A: extremes, luminance and divider operands.
  logic [7:0] hi, lo, d, lum;
  logic [8:0] sum, comp, sat_den, hue_den, half;
  logic       grey;
  logic [15:0] sat_num, r_num, g_num, b_num;
  hla_pkg::hla_maxc_e maxc;

  always_comb begin
    hi = (red_i > green_i) ? red_i : green_i;
    hi = (hi > blue_i) ? hi : blue_i;
    lo = (red_i < green_i) ? red_i : green_i;
    lo = (lo < blue_i) ? lo : blue_i;
    sum  = {1'b0, hi} + {1'b0, lo};
    d    = hi - lo;
    lum  = 8'(({1'b0, sum} + 10'd1) >> 1);
    grey = (d == 8'd0);
    comp = 9'd510 - sum;
    half = (lum <= hla_pkg::LUM_HALF) ? (sum >> 1) : (comp >> 1);
    if (grey) begin
      sat_den = 9'd1;
    end else if (lum <= hla_pkg::LUM_HALF) begin
      sat_den = sum;
    end else begin
      sat_den = comp;
    end
    sat_num = {d, 8'd0} - 16'(d) + 16'(half);
    hue_den = grey ? 9'd1 : {1'b0, d};
    r_num = 16'(hi - red_i) * 16'(hla_pkg::HUE_SIXTH) + 16'(d >> 1);
    g_num = 16'(hi - green_i) * 16'(hla_pkg::HUE_SIXTH) + 16'(d >> 1);
    b_num = 16'(hi - blue_i) * 16'(hla_pkg::HUE_SIXTH) + 16'(d >> 1);
    if (red_i == hi) begin
      maxc = hla_pkg::MAX_RED;
    end else if (green_i == hi) begin
      maxc = hla_pkg::MAX_GREEN;
    end else begin
      maxc = hla_pkg::MAX_BLUE;
    end
  end

  logic        a_valid_q;
  side_t       a_side_q;
  logic [15:0] a_sat_num_q, a_r_num_q, a_g_num_q, a_b_num_q;
  logic [8:0]  a_sat_den_q, a_hue_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_side_q    <= '{lum: lum, grey: grey, mode: mode_i, maxc: maxc};
    a_sat_num_q <= sat_num;
    a_r_num_q   <= r_num;
    a_g_num_q   <= g_num;
    a_b_num_q   <= b_num;
    a_sat_den_q <= sat_den;
    a_hue_den_q <= hue_den;
  end

  // Dividers for saturation and the three hue distances.
  logic [7:0] sat, dr, dg, db;

  hla_div u_div_sat (.clk_i, .num_i(a_sat_num_q), .den_i(a_sat_den_q), .quo_o(sat));
  hla_div u_div_r   (.clk_i, .num_i(a_r_num_q),   .den_i(a_hue_den_q), .quo_o(dr));
  hla_div u_div_g   (.clk_i, .num_i(a_g_num_q),   .den_i(a_hue_den_q), .quo_o(dg));
  hla_div u_div_b   (.clk_i, .num_i(a_b_num_q),   .den_i(a_hue_den_q), .quo_o(db));

  // Side data travels beside the dividers.
  logic  s_valid_q [hla_pkg::DIV_STAGES];
  side_t s_side_q  [hla_pkg::DIV_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < int'(hla_pkg::DIV_STAGES); k++) begin
        s_valid_q[k] <= 1'b0;
      end
    end else begin
      s_valid_q[0] <= a_valid_q;
      for (int k = 1; k < int'(hla_pkg::DIV_STAGES); k++) begin
        s_valid_q[k] <= s_valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s_side_q[0] <= a_side_q;
    for (int k = 1; k < int'(hla_pkg::DIV_STAGES); k++) begin
      s_side_q[k] <= s_side_q[k-1];
    end
  end

  // Stage H: hue from the distances, adjusted luminance.
  side_t             side;
  logic signed [9:0] hsum;
  logic [26:0]       dark_p;
  logic [7:0]        t, nlum;
  logic [8:0]        light;
  hla_pkg::hla_hsl_t hsl_d;

  always_comb begin
    side = s_side_q[hla_pkg::DIV_STAGES-1];
    case (side.maxc)
      hla_pkg::MAX_RED: begin
        hsum = $signed({2'b00, db}) - $signed({2'b00, dg});
      end
      hla_pkg::MAX_GREEN: begin
        hsum = $signed({2'b00, hla_pkg::HUE_THIRD}) + $signed({2'b00, dr})
             - $signed({2'b00, db});
      end
      default: begin
        hsum = $signed({2'b00, hla_pkg::HUE_TWO_THIRDS}) + $signed({2'b00, dg})
             - $signed({2'b00, dr});
      end
    endcase
    if (hsum < 0) begin
      hsum = hsum + $signed({2'b00, hla_pkg::FULL_SCALE});
    end

    dark_p = 27'(side.lum) * 27'(hla_pkg::DARK_MUL);
    t      = side.lum - 8'(dark_p >> hla_pkg::DARK_SHIFT);
    light  = {1'b0, side.lum} + 9'((hla_pkg::FULL_SCALE - side.lum) >> 2);
    if (side.mode) begin
      nlum = t - (t >> 1);
    end else if (light > 9'(hla_pkg::FULL_SCALE)) begin
      nlum = hla_pkg::FULL_SCALE;
    end else begin
      nlum = light[7:0];
    end

    hsl_d.hue  = side.grey ? 8'd0 : hsum[7:0];
    hsl_d.sat  = side.grey ? 8'd0 : sat;
    hsl_d.lum  = side.lum;
    hsl_d.nlum = nlum;
    hsl_d.grey = side.grey;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= s_valid_q[hla_pkg::DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    hsl_o <= hsl_d;
  end

endmodule

`default_nettype wire

// File: hw/rtl/hla_chan.sv
`default_nettype none

// Rebuilds one RGB channel from the hue sector and the two levels.
module hla_chan (
  input  wire logic       clk_i,
  input  wire logic [7:0] lo_i,
  input  wire logic [7:0] hi_i,
  input  wire logic [7:0] hue_i,
  output logic      [7:0] chan_o
);

  // Stage 1: sector and ramp product.
  hla_pkg::hla_sec_e sec_d, p1_sec_q, p2_sec_q;
  logic [5:0]  f;
  logic [13:0] prod_d, p1_prod_q;
  logic [7:0]  p1_lo_q, p1_hi_q, p2_lo_q, p2_hi_q;

  always_comb begin
    if (hue_i < hla_pkg::HUE_SIXTH) begin
      sec_d = hla_pkg::SEC_RAMP;
      f     = hue_i[5:0];
    end else if (hue_i < hla_pkg::HUE_HALF) begin
      sec_d = hla_pkg::SEC_HIGH;
      f     = 6'd0;
    end else if (hue_i < hla_pkg::HUE_TWO_THIRDS) begin
      sec_d = hla_pkg::SEC_RAMP;
      f     = 6'(hla_pkg::HUE_TWO_THIRDS - hue_i);
    end else begin
      sec_d = hla_pkg::SEC_LOW;
      f     = 6'd0;
    end
    prod_d = 14'(hi_i - lo_i) * 14'(f) + 14'(hla_pkg::HUE_TWELFTH);
  end

  always_ff @(posedge clk_i) begin
    p1_sec_q  <= sec_d;
    p1_prod_q <= prod_d;
    p1_lo_q   <= lo_i;
    p1_hi_q   <= hi_i;
  end

  // Stage 2: division by the sector width through its reciprocal.
  logic [28:0] recip_p;
  logic [8:0]  p2_q_q;

  assign recip_p = 29'(p1_prod_q) * 29'(hla_pkg::DIV42_MUL);

  always_ff @(posedge clk_i) begin
    p2_q_q   <= 9'(recip_p >> hla_pkg::DIV42_SHIFT);
    p2_sec_q <= p1_sec_q;
    p2_lo_q  <= p1_lo_q;
    p2_hi_q  <= p1_hi_q;
  end

  // Stage 3: select the level and cap it.
  logic [9:0] v;

  always_comb begin
    case (p2_sec_q)
      hla_pkg::SEC_RAMP: v = {2'b00, p2_lo_q} + {1'b0, p2_q_q};
      hla_pkg::SEC_HIGH: v = {2'b00, p2_hi_q};
      default:           v = {2'b00, p2_lo_q};
    endcase
  end

  always_ff @(posedge clk_i) begin
    chan_o <= (v > 10'(hla_pkg::FULL_SCALE)) ? hla_pkg::FULL_SCALE : v[7:0];
  end

endmodule

`default_nettype wire

// File: hw/rtl/hla_back.sv
`default_nettype none

// HSL to RGB conversion of the adjusted luminance.
module hla_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire hla_pkg::hla_hsl_t hsl_i,
  output logic                   valid_o,
  output logic [7:0]             red_o,
  output logic [7:0]             green_o,
  output logic [7:0]             blue_o,
  output logic [7:0]             hue_o,
  output logic [7:0]             sat_o,
  output logic [7:0]             lum_o
);

  // Stage M1: product for the upper level.
  logic              low;
  logic [8:0]        op;
  logic              m1_valid_q, m1_low_q;
  logic [15:0]       m1_prod_q;
  hla_pkg::hla_hsl_t m1_hsl_q;

  always_comb begin
    low = (hsl_i.nlum <= hla_pkg::LUM_HALF);
    op  = low ? ({1'b0, hla_pkg::FULL_SCALE} + {1'b0, hsl_i.sat}) : {1'b0, hsl_i.sat};
  end

  always_ff @(posedge clk_i) begin
    m1_prod_q <= 16'(17'(hsl_i.nlum) * 17'(op) + 17'(hla_pkg::HUE_HALF));
    m1_low_q  <= low;
    m1_hsl_q  <= hsl_i;
  end

  // Stage M2: both levels and the three shifted hues.
  logic [8:0]  q;
  logic [9:0]  upper;
  logic [7:0]  m2, m1, hr, hb;
  logic [8:0]  hr_sum;
  logic [7:0]  m2_lo_q, m2_hi_q, m2_hr_q, m2_hg_q, m2_hb_q;
  logic        m2_valid_q;
  hla_pkg::hla_hsl_t m2_hsl_q;

  always_comb begin
    q     = hla_pkg::div255(m1_prod_q);
    upper = 10'(m1_hsl_q.sat) + 10'(m1_hsl_q.nlum) - 10'(q);
    m2    = m1_low_q ? q[7:0] : upper[7:0];
    m1    = 8'({1'b0, m1_hsl_q.nlum, 1'b0} - 10'(m2));
    if (m1_hsl_q.grey) begin
      m2 = m1_hsl_q.nlum;
      m1 = m1_hsl_q.nlum;
    end
    hr_sum = {1'b0, m1_hsl_q.hue} + {1'b0, hla_pkg::HUE_THIRD};
    hr     = (hr_sum > 9'(hla_pkg::FULL_SCALE)) ? 8'(hr_sum - 9'(hla_pkg::FULL_SCALE))
                                               : hr_sum[7:0];
    hb     = (m1_hsl_q.hue < hla_pkg::HUE_THIRD)
           ? 8'(m1_hsl_q.hue + hla_pkg::FULL_SCALE - hla_pkg::HUE_THIRD)
           : (m1_hsl_q.hue - hla_pkg::HUE_THIRD);
  end

  always_ff @(posedge clk_i) begin
    m2_lo_q  <= m1;
    m2_hi_q  <= m2;
    m2_hr_q  <= hr;
    m2_hg_q  <= m1_hsl_q.hue;
    m2_hb_q  <= hb;
    m2_hsl_q <= m1_hsl_q;
  end

  hla_chan u_chan_r (.clk_i, .lo_i(m2_lo_q), .hi_i(m2_hi_q), .hue_i(m2_hr_q), .chan_o(red_o));
  hla_chan u_chan_g (.clk_i, .lo_i(m2_lo_q), .hi_i(m2_hi_q), .hue_i(m2_hg_q), .chan_o(green_o));
  hla_chan u_chan_b (.clk_i, .lo_i(m2_lo_q), .hi_i(m2_hi_q), .hue_i(m2_hb_q), .chan_o(blue_o));

  // Valid bits and the input color follow the channel units.
  logic              c_valid_q [hla_pkg::CHAN_STAGES];
  hla_pkg::hla_hsl_t c_hsl_q   [hla_pkg::CHAN_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_valid_q <= 1'b0;
      m2_valid_q <= 1'b0;
      for (int k = 0; k < int'(hla_pkg::CHAN_STAGES); k++) begin
        c_valid_q[k] <= 1'b0;
      end
    end else begin
      m1_valid_q   <= valid_i;
      m2_valid_q   <= m1_valid_q;
      c_valid_q[0] <= m2_valid_q;
      for (int k = 1; k < int'(hla_pkg::CHAN_STAGES); k++) begin
        c_valid_q[k] <= c_valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    c_hsl_q[0] <= m2_hsl_q;
    for (int k = 1; k < int'(hla_pkg::CHAN_STAGES); k++) begin
      c_hsl_q[k] <= c_hsl_q[k-1];
    end
  end

  assign valid_o = c_valid_q[hla_pkg::CHAN_STAGES-1];
  assign hue_o   = c_hsl_q[hla_pkg::CHAN_STAGES-1].hue;
  assign sat_o   = c_hsl_q[hla_pkg::CHAN_STAGES-1].sat;
  assign lum_o   = c_hsl_q[hla_pkg::CHAN_STAGES-1].lum;

endmodule

`default_nettype wire

// File: hw/rtl/hsl_luminance_adjust_core.sv
`default_nettype none

// Channel   | Direction | Handshake          | Word
// ----------+-----------+--------------------+----------------------------------------
// pixel in  | input     | start, busy        | in_red_i, in_green_i, in_blue_i
// result    | output    | valid_o strobe     | out_red_o/green/blue, hue/sat/lum_out_o
// config    | input     | cfg_we_i           | cfg_wdata_i (0 lightens, 1 darkens)
//
// One pixel is taken in every cycle; busy stays low. Each pixel passes through
// one operand stage, four divider stages (two quotient bits each),
// the hue and luminance stage, two stages for the HSL levels and three channel stages.
// Reset clears the valid bits and sets the mode to lighten. The receiver cannot stall,
// so every result is shown for exactly one cycle.
module hsl_luminance_adjust_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [7:0] in_red_i,
  input  wire logic [7:0] in_green_i,
  input  wire logic [7:0] in_blue_i,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  output logic            valid_o,
  output logic [7:0]      out_red_o,
  output logic [7:0]      out_green_o,
  output logic [7:0]      out_blue_o,
  output logic [7:0]      hue_out_o,
  output logic [7:0]      sat_out_o,
  output logic [7:0]      lum_out_o
);

  // Adjust mode register.
  logic mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // The pipeline never holds off a word.
  assign busy = 1'b0;

  logic              mid_valid;
  hla_pkg::hla_hsl_t mid_hsl;

  hla_front u_front (
    .clk_i,
    .rst_ni,
    .valid_i (start & ~busy),
    .mode_i  (mode_q),
    .red_i   (in_red_i),
    .green_i (in_green_i),
    .blue_i  (in_blue_i),
    .valid_o (mid_valid),
    .hsl_o   (mid_hsl)
  );

  hla_back u_back (
    .clk_i,
    .rst_ni,
    .valid_i (mid_valid),
    .hsl_i   (mid_hsl),
    .valid_o (valid_o),
    .red_o   (out_red_o),
    .green_o (out_green_o),
    .blue_o  (out_blue_o),
    .hue_o   (hue_out_o),
    .sat_o   (sat_out_o),
    .lum_o   (lum_out_o)
  );

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps
`default_nettype none

module testbench;

  localparam int unsigned LATENCY     = 11;
  localparam int unsigned RANDOM_WORDS = 1900;
  localparam int unsigned CYCLE_LIMIT = 200000;

  localparam logic MODE_LIGHTEN = 1'b0;
  localparam logic MODE_DARKEN  = 1'b1;

  // One adjusted pixel word.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] lum;
  } pixel_res_t;

  // Directed stimulus row; has_exp marks a result typed in by hand.
  typedef struct {
    logic       mode;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       has_exp;
    pixel_res_t exp_res;
  } pixel_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic [7:0] in_red_i;
  logic [7:0] in_green_i;
  logic [7:0] in_blue_i;
  logic       cfg_we_i;
  logic       cfg_wdata_i;
  logic       valid_o;
  logic [7:0] out_red_o;
  logic [7:0] out_green_o;
  logic [7:0] out_blue_o;
  logic [7:0] hue_out_o;
  logic [7:0] sat_out_o;
  logic [7:0] lum_out_o;

  pixel_res_t  pending_pixels[$];
  logic        mode_shadow;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  hsl_luminance_adjust_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_red_i   (in_red_i),
    .in_green_i (in_green_i),
    .in_blue_i  (in_blue_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .valid_o    (valid_o),
    .out_red_o  (out_red_o),
    .out_green_o(out_green_o),
    .out_blue_o (out_blue_o),
    .hue_out_o  (hue_out_o),
    .sat_out_o  (sat_out_o),
    .lum_out_o  (lum_out_o)
  );

  always #5 clk_i = ~clk_i;

  // Value of one channel at hue position h between levels lo and hi.
  function automatic int sector_level(int lo, int hi, int h);
    int hh;
    hh = h;
    if (hh < 0) begin
      hh += 255;
    end else if (hh > 255) begin
      hh -= 255;
    end
    if (hh < 42) begin
      return lo + ((hi - lo) * hh + 21) / 42;
    end
    if (hh < 127) begin
      return hi;
    end
    if (hh < 170) begin
      return lo + ((hi - lo) * (170 - hh) + 21) / 42;
    end
    return lo;
  endfunction

  function automatic logic [7:0] scale_channel(int v);
    int c;
    c = (v * 255 + 127) / 255;
    return (c > 255) ? 8'd255 : 8'(c);
  endfunction

  // Predicted adjusted pixel for one input under the given mode.
  function automatic pixel_res_t adjust_pixel(logic mode, logic [7:0] ri, logic [7:0] gi,
                                              logic [7:0] bi);
    int r, g, b, hi, lo, sum, d, l, s, h, dr, dg, db, nl, m1, m2;
    pixel_res_t res;
    r = ri; g = gi; b = bi;
    hi = (r > g) ? r : g;
    hi = (hi > b) ? hi : b;
    lo = (r < g) ? r : g;
    lo = (lo < b) ? lo : b;
    sum = hi + lo;
    d = hi - lo;
    l = (sum * 255 + 255) / 510;
    s = 0;
    h = 0;
    if (d != 0) begin
      if (l <= 127) begin
        s = (d * 255 + sum / 2) / sum;
      end else begin
        s = (d * 255 + (510 - sum) / 2) / (510 - sum);
      end
      dr = ((hi - r) * 42 + d / 2) / d;
      dg = ((hi - g) * 42 + d / 2) / d;
      db = ((hi - b) * 42 + d / 2) / d;
      if (r == hi) begin
        h = db - dg;
      end else if (g == hi) begin
        h = 85 + dr - db;
      end else begin
        h = 170 + dg - dr;
      end
      if (h < 0) begin
        h += 255;
      end else if (h > 255) begin
        h -= 255;
      end
    end
    if (mode == MODE_LIGHTEN) begin
      nl = l + (255 - l) / 4;
      if (nl > 255) nl = 255;
    end else begin
      nl = l - (l * 333) / 1000;
      nl = nl - nl / 2;
    end
    if (s == 0) begin
      res.red = 8'(nl);
      res.green = 8'(nl);
      res.blue = 8'(nl);
    end else begin
      if (nl <= 127) begin
        m2 = (nl * (255 + s) + 127) / 255;
      end else begin
        m2 = s + nl - (s * nl + 127) / 255;
      end
      m1 = 2 * nl - m2;
      res.red = scale_channel(sector_level(m1, m2, h + 85));
      res.green = scale_channel(sector_level(m1, m2, h));
      res.blue = scale_channel(sector_level(m1, m2, h - 85));
    end
    res.hue = 8'(h);
    res.sat = 8'(s);
    res.lum = 8'(l);
    return res;
  endfunction

  function automatic pixel_res_t grey_res(logic [7:0] nl, logic [7:0] l);
    return '{red: nl, green: nl, blue: nl, hue: 8'd0, sat: 8'd0, lum: l};
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result checker: every strobed word is compared with the oldest prediction.
  always @(posedge clk_i) begin
    pixel_res_t got, want;
    if (rst_ni && valid_o) begin
      got = '{red: out_red_o, green: out_green_o, blue: out_blue_o,
              hue: hue_out_o, sat: sat_out_o, lum: lum_out_o};
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        error_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (got.red !== want.red)
          $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
        if (got.green !== want.green)
          $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
        if (got.blue !== want.blue)
          $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
        if (got.hue !== want.hue)
          $display("%0t: hue expected %0d actual %0d", $time, want.hue, got.hue);
        if (got.sat !== want.sat)
          $display("%0t: sat expected %0d actual %0d", $time, want.sat, got.sat);
        if (got.lum !== want.lum)
          $display("%0t: lum expected %0d actual %0d", $time, want.lum, got.lum);
        if (got !== want) error_count++;
      end
    end
  end

  // Drive one pixel and hold it until the block takes it.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic has_exp,
                            pixel_res_t exp_res);
    start <= 1'b1;
    in_red_i <= r;
    in_green_i <= g;
    in_blue_i <= b;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_pixels.push_back(has_exp ? exp_res : adjust_pixel(mode_shadow, r, g, b));
  endtask

  // Random gap after a word: mostly none or short, now and then long.
  task automatic idle_gap();
    int unsigned n;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) n = 0;
    else if (pick < 95) n = $urandom_range(1, 3);
    else n = $urandom_range(5, 30);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Let the pipeline drain, then write the mode register.
  task automatic set_mode(logic mode);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_shadow = mode;
  endtask

  pixel_row_t directed[$];

  initial begin
    pixel_res_t none;
    logic [7:0] r, g, b;
    int unsigned pick;
    logic [7:0] base;
    none = '0;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    in_red_i = '0;
    in_green_i = '0;
    in_blue_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    mode_shadow = MODE_LIGHTEN;

    // Grey extremes are read straight off the formulas; the rest use the predictor.
    directed = '{
      '{MODE_LIGHTEN, 8'd0,   8'd0,   8'd0,   1'b1, grey_res(8'd63,  8'd0)},
      '{MODE_LIGHTEN, 8'd255, 8'd255, 8'd255, 1'b1, grey_res(8'd255, 8'd255)},
      '{MODE_LIGHTEN, 8'd128, 8'd128, 8'd128, 1'b0, none},
      '{MODE_LIGHTEN, 8'd255, 8'd0,   8'd0,   1'b0, none},
      '{MODE_LIGHTEN, 8'd0,   8'd255, 8'd0,   1'b0, none},
      '{MODE_LIGHTEN, 8'd0,   8'd0,   8'd255, 1'b0, none},
      '{MODE_LIGHTEN, 8'd255, 8'd0,   8'd1,   1'b0, none},
      '{MODE_LIGHTEN, 8'd255, 8'd255, 8'd0,   1'b0, none},
      '{MODE_LIGHTEN, 8'd1,   8'd0,   8'd0,   1'b0, none},
      '{MODE_LIGHTEN, 8'd254, 8'd255, 8'd255, 1'b0, none},
      '{MODE_LIGHTEN, 8'd170, 8'd85,  8'd200, 1'b0, none},
      '{MODE_DARKEN,  8'd0,   8'd0,   8'd0,   1'b1, grey_res(8'd0,   8'd0)},
      '{MODE_DARKEN,  8'd255, 8'd255, 8'd255, 1'b1, grey_res(8'd86,  8'd255)},
      '{MODE_DARKEN,  8'd255, 8'd0,   8'd0,   1'b0, none},
      '{MODE_DARKEN,  8'd0,   8'd255, 8'd255, 1'b0, none},
      '{MODE_DARKEN,  8'd255, 8'd0,   8'd255, 1'b0, none},
      '{MODE_DARKEN,  8'd255, 8'd1,   8'd0,   1'b0, none},
      '{MODE_DARKEN,  8'd0,   8'd1,   8'd255, 1'b0, none},
      '{MODE_DARKEN,  8'd100, 8'd50,  8'd25,  1'b0, none},
      '{MODE_LIGHTEN, 8'd12,  8'd240, 8'd99,  1'b0, none}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; the mode register changes only when the table asks.
    foreach (directed[i]) begin
      if (directed[i].mode != mode_shadow) set_mode(directed[i].mode);
      send_pixel(directed[i].r, directed[i].g, directed[i].b, directed[i].has_exp,
                 directed[i].exp_res);
      idle_gap();
    end

    // Random phases with alternating modes; grey, near-grey and extreme red/green pixels mixed in.
    for (int phase = 0; phase < 6; phase++) begin
      set_mode(phase[0] ? MODE_LIGHTEN : MODE_DARKEN);
      for (int n = 0; n < RANDOM_WORDS / 6; n++) begin
        pick = $urandom_range(0, 9);
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
        if (pick == 0) begin
          g = r;
          b = r;
        end else if (pick == 1) begin
          base = 8'($urandom_range(0, 254));
          r = base;
          g = base + 8'($urandom_range(0, 1));
          b = base + 8'($urandom_range(0, 1));
        end else if (pick == 2) begin
          r = 8'($urandom_range(0, 1)) * 8'd255;
          g = 8'($urandom_range(0, 1)) * 8'd255;
        end
        send_pixel(r, g, b, 1'b0, none);
        if ($urandom_range(0, 3) != 0) idle_gap();
      end
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
